### hw/rtl/cddc_pkg.sv
// Shared types, constants and calendar helper functions for the day counter.
package cddc_pkg;

  // Calendar limits for accepted dates
  localparam int FIRST_YEAR = 1970;
  localparam int LAST_YEAR  = 2099;
  localparam int DIFF_LIMIT = 65535;
  // 1970 mod 400, seed of the century counter
  localparam int FIRST_YEAR_MOD400 = 370;

  // Field widths of the stream payloads
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEARF_W  = 12;
  localparam int OFFSET_W = 17;
  localparam int DCOUNT_W = 16;
  localparam int DIFF_W   = 17;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_SHIFT = 2'd1,
    ACT_DIFF  = 2'd2,
    ACT_NOP   = 2'd3
  } cddc_act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GIVEN_YEARS,
    ST_FIN,
    ST_APPLY,
    ST_CONV_INIT,
    ST_CONV_YEARS,
    ST_CONV_MONTHS,
    ST_DONE
  } cddc_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic given_step;
    logic fin;
    logic apply;
    logic conv_init;
    logic year_step;
    logic month_step;
    logic out_load;
  } cddc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic range_ok;
    logic year_reached;
    logic year_fits;
    logic month_more;
  } cddc_sts_t;

  // Length of a month, month 1..12
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of the month
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] n;
    case (month)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

### hw/rtl/cddc_ctrl.sv
// Sequencing state machine for the day counter.
module cddc_ctrl import cddc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  cddc_sts_t sts,
  output cddc_cmd_t cmd
);

  cddc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_GIVEN_YEARS;
        end
      end
      ST_GIVEN_YEARS: begin
        if (!sts.range_ok || sts.year_reached) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.given_step = 1'b1;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_CONV_INIT;
      end
      ST_CONV_INIT: begin
        cmd.conv_init = 1'b1;
        state_nxt     = ST_CONV_YEARS;
      end
      ST_CONV_YEARS: begin
        if (sts.year_fits) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = ST_CONV_MONTHS;
        end
      end
      ST_CONV_MONTHS: begin
        if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### hw/rtl/cddc_dp.sv
// Datapath: stored count, year and month stepping, shift and difference arithmetic.
module cddc_dp import cddc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  cddc_cmd_t              cmd,
  output cddc_sts_t              sts,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int YEAR_W = $clog2(FIRST_YEAR + (2 ** COUNT_BITS) / 365 + 2);
  localparam int SUM_W  = COUNT_BITS + 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic signed [COUNT_BITS:0] DLIM_POS = (COUNT_BITS + 1)'(DIFF_LIMIT);
  localparam logic signed [COUNT_BITS:0] DLIM_NEG = -DLIM_POS;

  // Captured item
  cddc_act_t                act_r;
  logic [DAY_W-1:0]         gday_r;
  logic [MONTH_W-1:0]       gmon_r;
  logic [YEARF_W-1:0]       gyear_r;
  logic signed [OFFSET_W-1:0] off_r;

  // Working registers
  logic [YEAR_W-1:0]        yr_r;
  logic [8:0]               m400_r;
  logic [COUNT_BITS-1:0]    acc_r;
  logic [COUNT_BITS-1:0]    gcount_r;
  logic [COUNT_BITS-1:0]    stored_r;
  logic [COUNT_BITS-1:0]    rem_r;
  logic [MONTH_W-1:0]       mon_r;
  logic                     valid_r;
  logic                     clamp_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;

  logic                     leap;
  logic [8:0]               ylen;
  logic [4:0]               mlen_cur;
  logic [4:0]               mlen_given;
  logic                     needs_given;
  logic                     day_ok;
  logic [COUNT_BITS-1:0]    cnt;
  logic signed [SUM_W-1:0]  shift_sum;
  logic signed [COUNT_BITS:0] diff_full;
  logic signed [COUNT_BITS:0] diff_sat;
  logic [COUNT_BITS-1:0]    stored_nxt;
  logic                     clamp_nxt;
  logic signed [DIFF_W-1:0] diff_nxt;

  // Leap rule from the low year bits and the position within 400 years
  assign leap = (yr_r[1:0] == 2'b00) && (m400_r != 9'd100) && (m400_r != 9'd200)
                && (m400_r != 9'd300);
  assign ylen       = year_len(leap);
  assign mlen_cur   = month_len(mon_r, leap);
  assign mlen_given = month_len(gmon_r, leap);

  assign needs_given = (act_r == ACT_SET) || (act_r == ACT_DIFF);

  // Status for the controller
  always_comb begin
    sts.range_ok     = (gyear_r >= YEARF_W'(FIRST_YEAR)) && (gyear_r <= YEARF_W'(LAST_YEAR))
                       && (gmon_r >= 4'd1) && (gmon_r <= 4'd12);
    sts.year_reached = (yr_r == YEAR_W'(gyear_r));
    sts.year_fits    = (rem_r >= COUNT_BITS'(ylen));
    sts.month_more   = (mon_r != 4'd12) && (rem_r >= COUNT_BITS'(mlen_cur));
  end

  // Count of the given date once the year walk has reached its year
  assign day_ok = (gday_r != 5'd0) && (gday_r <= mlen_given);
  assign cnt = acc_r + COUNT_BITS'(days_before(gmon_r))
               + COUNT_BITS'((gmon_r > 4'd2) && leap) + COUNT_BITS'(gday_r) - COUNT_BITS'(1);

  // Shift with saturation, difference with saturation
  assign shift_sum = $signed({2'b00, stored_r}) + SUM_W'(off_r);
  assign diff_full = $signed({1'b0, stored_r}) - $signed({1'b0, gcount_r});

  always_comb begin
    if (diff_full > DLIM_POS) begin
      diff_sat = DLIM_POS;
    end else if (diff_full < DLIM_NEG) begin
      diff_sat = DLIM_NEG;
    end else begin
      diff_sat = diff_full;
    end
  end

  always_comb begin
    stored_nxt = stored_r;
    clamp_nxt  = 1'b0;
    diff_nxt   = '0;
    case (act_r)
      ACT_SET: stored_nxt = gcount_r;
      ACT_SHIFT: begin
        if (shift_sum < 0) begin
          stored_nxt = '0;
          clamp_nxt  = 1'b1;
        end else if (shift_sum > $signed({2'b00, COUNT_MAX})) begin
          stored_nxt = COUNT_MAX;
          clamp_nxt  = 1'b1;
        end else begin
          stored_nxt = shift_sum[COUNT_BITS-1:0];
        end
      end
      ACT_DIFF: diff_nxt = diff_sat[DIFF_W-1:0];
      default:  stored_nxt = stored_r;
    endcase
  end

  // Stored count is the only state kept across items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
    end else if (cmd.apply) begin
      stored_r <= stored_nxt;
    end
  end

  // Capture the item and run the year and month walks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= cddc_act_t'(in_tuser);
      gday_r  <= in_tdata[4:0];
      gmon_r  <= in_tdata[8:5];
      gyear_r <= in_tdata[20:9];
      off_r   <= $signed(in_tdata[37:21]);
      yr_r    <= YEAR_W'(FIRST_YEAR);
      m400_r  <= 9'(FIRST_YEAR_MOD400);
      acc_r   <= '0;
      clamp_r <= 1'b0;
      diff_r  <= '0;
    end
    if (cmd.conv_init) begin
      yr_r   <= YEAR_W'(FIRST_YEAR);
      m400_r <= 9'(FIRST_YEAR_MOD400);
      rem_r  <= stored_r;
      mon_r  <= 4'd1;
    end
    // advance one year, summing or consuming its length
    if (cmd.given_step || cmd.year_step) begin
      yr_r   <= yr_r + YEAR_W'(1);
      m400_r <= (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
    end
    if (cmd.given_step) begin
      acc_r <= acc_r + COUNT_BITS'(ylen);
    end
    if (cmd.year_step) begin
      rem_r <= rem_r - COUNT_BITS'(ylen);
    end
    if (cmd.month_step) begin
      rem_r <= rem_r - COUNT_BITS'(mlen_cur);
      mon_r <= mon_r + 4'd1;
    end
    if (cmd.fin) begin
      valid_r  <= sts.range_ok && day_ok && needs_given;
      gcount_r <= (sts.range_ok && day_ok) ? cnt : '0;
    end
    if (cmd.apply) begin
      clamp_r <= clamp_nxt;
      diff_r  <= diff_nxt;
    end
    // fields from the lowest bit up: day, month, year, count, difference, flags
    if (cmd.out_load) begin
      out_tdata_r <= {clamp_r, valid_r, diff_r, stored_r[DCOUNT_W-1:0], yr_r[YEARF_W-1:0],
                      mon_r, 5'(rem_r[DAY_W-1:0] + 5'd1)};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

### hw/rtl/civil_date_day_counter.sv
// Each item runs through load, a walk from 1970 to the given year (taken only when the given
// year and month are in range, for every action), fin, apply, a conversion start, then walks
// over the whole years and the whole months of the stored count, and waits in the done state
// until the output register is free. One item is in work at a time, and the next input
// transfer can come in the cycle after the result loads.
// Reset (synchronous, rst_n low) sets the stored count to 0, 1 January 1970.
module civil_date_day_counter import cddc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata: in_day[4:0], in_month[8:5], in_year[20:9], offset[37:21], zero[39:38]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: action[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: out_day[4:0], out_month[8:5], out_year[20:9], day_count[36:21],
  //            difference[53:37], date_valid[54], clamped[55]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cddc_cmd_t cmd;
  cddc_sts_t sts;

  // Sequencer
  cddc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic and storage
  cddc_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

### verif/civil_date_day_counter_tb.sv
// Self-checking testbench for the civil date day counter stream block.
module civil_date_day_counter_tb;

  localparam int COUNT_BITS    = 16;
  localparam int COUNT_TOP     = (1 << COUNT_BITS) - 1;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int PHASES        = 4;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 400;

  typedef enum int {
    GAPS_NONE,
    GAPS_SENDER,
    GAPS_RECEIVER,
    GAPS_BOTH
  } gap_mode_t;

  typedef struct {
    cddc_pkg::cddc_act_t act;
    logic [4:0]          day;
    logic [3:0]          month;
    logic [11:0]         year;
    logic [16:0]         offset;
  } date_request_t;

  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [15:0] count;
    logic [16:0] difference;
    logic        valid;
    logic        clamped;
  } date_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [cddc_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = cddc_pkg::ACT_NOP;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [cddc_pkg::OUT_TDATA_W-1:0] out_tdata;

  date_request_t pending_requests[$];
  date_report_t  expected_reports[$];

  // Model state: day count held by the block
  int unsigned held_day_count = 0;

  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  bit  in_taken = 1'b0;
  int  fail_count = 0;
  int  reports_checked = 0;
  int  accepted_by_action[4] = '{0, 0, 0, 0};
  int  rejected_dates = 0;
  int  saturations = 0;
  int  quiet_cycles = 0;

  civil_date_day_counter #(
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Gregorian calendar arithmetic
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_of_month(int unsigned m, int unsigned y);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit calendar_date_ok(int unsigned d, int unsigned m, int unsigned y);
    if (y < cddc_pkg::FIRST_YEAR || y > cddc_pkg::LAST_YEAR || m < 1 || m > 12)
      return 1'b0;
    return d >= 1 && d <= days_of_month(m, y);
  endfunction

  // Days from 1 Jan 1970 to a date already known to be valid
  function automatic int unsigned day_number_of_date(int unsigned d, int unsigned m,
                                                     int unsigned y);
    int unsigned n;
    n = 0;
    for (int unsigned i = cddc_pkg::FIRST_YEAR; i < y; i++)
      n += leap_year(i) ? 366 : 365;
    for (int unsigned i = 1; i < m; i++)
      n += days_of_month(i, y);
    return n + d - 1;
  endfunction

  function automatic void split_day_count(input int unsigned n, output int unsigned d,
                                          output int unsigned m, output int unsigned y);
    y = cddc_pkg::FIRST_YEAR;
    m = 1;
    while (n >= (leap_year(y) ? 366 : 365)) begin
      n -= leap_year(y) ? 366 : 365;
      y++;
    end
    while (m < 12 && n >= days_of_month(m, y)) begin
      n -= days_of_month(m, y);
      m++;
    end
    d = n + 1;
  endfunction

  // Apply one request to the held count and build the report it causes
  function automatic date_report_t apply_date_request(date_request_t req);
    date_report_t rep;
    longint       sum;
    longint       delta;
    int unsigned  given;
    int unsigned  d, m, y;
    bit           ok;
    delta = 0;
    rep.valid = 1'b0;
    rep.clamped = 1'b0;
    ok = calendar_date_ok(req.day, req.month, req.year);
    given = ok ? day_number_of_date(req.day, req.month, req.year) : 0;
    case (req.act)
      cddc_pkg::ACT_SET: begin
        held_day_count = given & COUNT_TOP;
        rep.valid = ok;
      end
      cddc_pkg::ACT_SHIFT: begin
        sum = longint'(held_day_count) + longint'($signed(req.offset));
        if (sum < 0) begin
          sum = 0;
          rep.clamped = 1'b1;
        end else if (sum > COUNT_TOP) begin
          sum = COUNT_TOP;
          rep.clamped = 1'b1;
        end
        held_day_count = int'(sum);
      end
      cddc_pkg::ACT_DIFF: begin
        rep.valid = ok;
        delta = longint'(held_day_count) - longint'(given);
        if (delta > cddc_pkg::DIFF_LIMIT) delta = cddc_pkg::DIFF_LIMIT;
        if (delta < -cddc_pkg::DIFF_LIMIT) delta = -cddc_pkg::DIFF_LIMIT;
      end
      default: ;
    endcase
    split_day_count(held_day_count, d, m, y);
    rep.day = 5'(d);
    rep.month = 4'(m);
    rep.year = 12'(y);
    rep.count = 16'(held_day_count);
    rep.difference = 17'(delta);
    return rep;
  endfunction

  task automatic add_request(cddc_pkg::cddc_act_t act, int d, int m, int y, int off);
    date_request_t req;
    req.act = act;
    req.day = 5'(d);
    req.month = 4'(m);
    req.year = 12'(y);
    req.offset = 17'(off);
    pending_requests.push_back(req);
  endtask

  // Mostly well-formed dates and modest offsets, with noise on every field
  function automatic date_request_t random_date_request();
    date_request_t req;
    int unsigned   pick;
    int            mag;
    pick = $urandom_range(99);
    req.act = pick < 35 ? cddc_pkg::ACT_SET :
              pick < 65 ? cddc_pkg::ACT_SHIFT :
              pick < 92 ? cddc_pkg::ACT_DIFF : cddc_pkg::ACT_NOP;
    req.day = 5'($urandom);
    req.month = 4'($urandom);
    req.year = 12'($urandom);
    req.offset = 17'($urandom);
    if ((req.act == cddc_pkg::ACT_SET || req.act == cddc_pkg::ACT_DIFF) &&
        $urandom_range(99) < 85) begin
      req.year = 12'($urandom_range(cddc_pkg::LAST_YEAR, cddc_pkg::FIRST_YEAR));
      req.month = 4'($urandom_range(12, 1));
      if ($urandom_range(9) == 0)
        req.day = 5'(days_of_month(req.month, req.year));
      else
        req.day = 5'($urandom_range(days_of_month(req.month, req.year), 1));
    end
    if (req.act == cddc_pkg::ACT_SHIFT) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        mag = $urandom_range(400);
        req.offset = 17'($urandom_range(1) ? mag : -mag);
      end else if (pick < 90) begin
        mag = $urandom_range(20000);
        req.offset = 17'($urandom_range(1) ? mag : -mag);
      end
    end
    return req;
  endfunction

  // Report a field mismatch
  task automatic check_field(string name, longint exp, longint got);
    if (exp != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
    end
  endtask

  // Drive requests and receiver back-pressure on the falling edge
  always @(negedge clk) begin : drive_stream
    date_request_t req;
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, req.offset, req.year, req.month, req.day};
          in_tuser <= req.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Check each result transfer, then predict for each request transfer
  always @(posedge clk) begin : watch_stream
    date_request_t req;
    date_report_t  exp;
    in_taken = in_tvalid && in_tready;
    if (out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result transfer, tdata %h", $time, out_tdata);
      end else begin
        exp = expected_reports.pop_front();
        reports_checked++;
        check_field("out_day", exp.day, out_tdata[4:0]);
        check_field("out_month", exp.month, out_tdata[8:5]);
        check_field("out_year", exp.year, out_tdata[20:9]);
        check_field("day_count", exp.count, out_tdata[36:21]);
        check_field("difference", $signed(exp.difference), $signed(out_tdata[53:37]));
        check_field("date_valid", exp.valid, out_tdata[54]);
        check_field("clamped", exp.clamped, out_tdata[55]);
      end
    end
    if (in_taken) begin
      req.act = cddc_pkg::cddc_act_t'(in_tuser);
      req.day = in_tdata[4:0];
      req.month = in_tdata[8:5];
      req.year = in_tdata[20:9];
      req.offset = in_tdata[37:21];
      exp = apply_date_request(req);
      accepted_by_action[req.act]++;
      if ((req.act == cddc_pkg::ACT_SET || req.act == cddc_pkg::ACT_DIFF) && !exp.valid)
        rejected_dates++;
      if (exp.clamped) saturations++;
      expected_reports.push_back(exp);
    end
  end

  // Abort when work is outstanding but nothing moves
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pending_requests.size() == 0 && !in_tvalid && expected_reports.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, expected_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Reset, then run the traffic phases
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (gap_mode_t'(phase))
        GAPS_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        GAPS_SENDER:   begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
        GAPS_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
        default:       begin sender_idle_pct = 17; receiver_stall_pct = 17; end
      endcase
      if (phase == 0) begin
        // Calendar extremes, leap rules, rejected dates and saturation
        add_request(cddc_pkg::ACT_NOP, 0, 0, 0, 0);
        add_request(cddc_pkg::ACT_SET, 1, 1, 1970, 0);
        add_request(cddc_pkg::ACT_SET, 31, 12, 2099, 0);
        add_request(cddc_pkg::ACT_SHIFT, 0, 0, 0, 65535);
        add_request(cddc_pkg::ACT_DIFF, 1, 1, 1970, 0);
        add_request(cddc_pkg::ACT_DIFF, 31, 15, 4095, 0);
        add_request(cddc_pkg::ACT_SHIFT, 31, 15, 4095, -65536);
        add_request(cddc_pkg::ACT_SHIFT, 0, 0, 0, -1);
        add_request(cddc_pkg::ACT_DIFF, 31, 12, 2099, 0);
        add_request(cddc_pkg::ACT_SET, 29, 2, 2000, 0);
        add_request(cddc_pkg::ACT_SET, 29, 2, 2100, 0);
        add_request(cddc_pkg::ACT_SET, 29, 2, 2096, 0);
        add_request(cddc_pkg::ACT_SET, 29, 2, 2001, 0);
        add_request(cddc_pkg::ACT_SET, 0, 5, 2010, 0);
        add_request(cddc_pkg::ACT_SET, 31, 4, 2010, 0);
        add_request(cddc_pkg::ACT_SET, 15, 0, 2010, 0);
        add_request(cddc_pkg::ACT_SET, 15, 13, 2010, 0);
        add_request(cddc_pkg::ACT_SET, 31, 15, 4095, -1);
        add_request(cddc_pkg::ACT_SET, 1, 1, 1969, 0);
        add_request(cddc_pkg::ACT_SHIFT, 0, 0, 0, 1);
        add_request(cddc_pkg::ACT_DIFF, 30, 2, 2000, 0);
        add_request(cddc_pkg::ACT_SET, 31, 12, 2099, 0);
        add_request(cddc_pkg::ACT_SHIFT, 0, 0, 0, 6000);
        add_request(cddc_pkg::ACT_DIFF, 1, 3, 2000, 0);
        add_request(cddc_pkg::ACT_NOP, 31, 15, 4095, -1);
      end
      repeat (RANDOM_ITEMS / PHASES) pending_requests.push_back(random_date_request());
      // Hold the phase change until the block has drained
      while (pending_requests.size() != 0 || in_tvalid || expected_reports.size() != 0)
        @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d set, %0d shift, %0d diff, %0d no-op requests.",
             reports_checked, accepted_by_action[cddc_pkg::ACT_SET],
             accepted_by_action[cddc_pkg::ACT_SHIFT], accepted_by_action[cddc_pkg::ACT_DIFF],
             accepted_by_action[cddc_pkg::ACT_NOP]);
    $display("Rejected dates: %0d, saturated shifts: %0d, over four back-pressure phases.",
             rejected_dates, saturations);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
